// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the RTL that carries concurrent checks.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every rising edge outside reset
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// cond must never be true outside reset
`define ASSERT_NEVER(name, cond, msg) \
  `ASSERT_CLK(name, !(cond), msg)

`endif

// ----- rtl/core/sfd_pkg.sv -----
// Package for the stuffed frame deframer: line codes, phase and result kinds,
// and the byte-wide CRC16-CCITT update. No dependencies.
package sfd_pkg;

  localparam logic [7:0] BYTE_SOF     = 8'hC0;
  localparam logic [7:0] BYTE_ESC     = 8'hDB;
  localparam logic [7:0] BYTE_ESC_SOF = 8'hDC;
  localparam logic [7:0] BYTE_ESC_ESC = 8'hDD;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CNT_MAX  = 16'hFFFF;

  localparam logic [2:0] HDR_LAST = 3'd6;

  typedef enum logic [1:0] {
    PH_WAIT    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_CRC     = 2'd3
  } phase_t;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_GOOD    = 2'd1;
  localparam logic [1:0] KIND_CRC_ERR = 2'd2;
  localparam logic [1:0] KIND_ABORT   = 2'd3;

  // MSB-first CRC16-CCITT, one byte
  function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/core/stuffed_frame_deframer_crc16_top.sv -----
// Stuffed frame deframer with CRC16-CCITT check, top level.
// Depends on sfd_pkg and assert_macros.svh.
//
// Usage:
//   Input channel in_valid/in_ready/in_line_byte carries one raw line byte per
//   item. 0xC0 starts a frame, 0xDB escapes the next byte (0xDC or 0xDD).
//   Output channel out_valid/out_ready carries at most one result per input
//   item: a payload byte (kind 0, out_last_payload on the final one), a
//   verdict (kind 1 good, kind 2 CRC mismatch) with the header fields, or an
//   abort (kind 3) when a frame dies after payload output began.
//   out_crc_error_count shows the saturating mismatch counter on every result.
// Timing:
//   An item sits in the input register, where the destuff, header,
//   CRC and verdict logic runs, and its result, if any, lands in the output
//   register, which drives out_valid. One item per cycle sustained while the
//   output is taken, set by the byte-wide CRC update in the state loop.
// Stall:
//   While the output register holds an untaken result, the input register
//   holds its item and in_ready drops once both are full; nothing is lost.
// Reset:
//   rst_n synchronous, active low. Both registers empty, the deframer waits
//   for 0xC0, CRC preset to 0xFFFF, error counter and header fields zero.
`include "assert_macros.svh"

module stuffed_frame_deframer_crc16_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_line_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_payload_byte,
  output logic        out_last_payload,
  output logic [7:0]  out_address,
  output logic [7:0]  out_command,
  output logic [7:0]  out_flag_bits,
  output logic [15:0] out_sequence_res,
  output logic [15:0] out_payload_length,
  output logic [15:0] out_crc_error_count
);
  import sfd_pkg::*;

  // input register
  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_adv;

  // deframer state
  phase_t      phase_r, phase_nxt;
  logic        esc_r, esc_nxt;
  logic [2:0]  hdr_cnt_r, hdr_cnt_nxt;
  logic [7:0]  addr_r, addr_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [7:0]  flags_r, flags_nxt;
  logic [15:0] seq_r, seq_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] pay_cnt_r, pay_cnt_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  crc_hi_r, crc_hi_nxt;
  logic        crc_cnt_r, crc_cnt_nxt;
  logic [15:0] err_cnt_r, err_cnt_nxt;

  // result of the current item
  logic        res_valid;
  logic [1:0]  res_kind;
  logic [7:0]  res_pbyte;
  logic        res_last;
  logic        res_hdr;

  // scratch
  logic        started;
  logic        take;
  logic        bad;
  logic [7:0]  db;
  logic [15:0] crc_upd;
  logic [15:0] pay_cnt_inc;
  logic [15:0] len_new;

  // output register
  logic        out_valid_r;
  logic [1:0]  out_kind_r;
  logic [7:0]  out_pbyte_r;
  logic        out_last_r;
  logic [7:0]  out_addr_r;
  logic [7:0]  out_cmd_r;
  logic [7:0]  out_flags_r;
  logic [15:0] out_seq_r;
  logic [15:0] out_len_r;
  logic [15:0] out_err_r;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_line_byte;
    end
  end

  // destuffed data byte
  assign db = (esc_r && (s1_byte_r == BYTE_ESC_SOF)) ? BYTE_SOF :
              (esc_r && (s1_byte_r == BYTE_ESC_ESC)) ? BYTE_ESC : s1_byte_r;

  assign started = ((phase_r == PH_PAYLOAD) && (pay_cnt_r != 16'd0)) ||
                   ((phase_r == PH_CRC) && (len_r != 16'd0));
  assign crc_upd     = crc16_update(crc_r, db);
  assign pay_cnt_inc = pay_cnt_r + 16'd1;
  assign len_new     = {db, len_r[7:0]};

  always_comb begin
    phase_nxt   = phase_r;
    esc_nxt     = esc_r;
    hdr_cnt_nxt = hdr_cnt_r;
    addr_nxt    = addr_r;
    cmd_nxt     = cmd_r;
    flags_nxt   = flags_r;
    seq_nxt     = seq_r;
    len_nxt     = len_r;
    pay_cnt_nxt = pay_cnt_r;
    crc_nxt     = crc_r;
    crc_hi_nxt  = crc_hi_r;
    crc_cnt_nxt = crc_cnt_r;
    err_cnt_nxt = err_cnt_r;
    res_valid   = 1'b0;
    res_kind    = KIND_PAYLOAD;
    res_pbyte   = 8'h00;
    res_last    = 1'b0;
    res_hdr     = 1'b0;
    take        = 1'b0;
    bad         = 1'b0;

    if (s1_byte_r == BYTE_SOF) begin
      bad = 1'b1;
    end else if (phase_r != PH_WAIT) begin
      if (esc_r) begin
        esc_nxt = 1'b0;
        if ((s1_byte_r == BYTE_ESC_SOF) || (s1_byte_r == BYTE_ESC_ESC)) begin
          take = 1'b1;
        end else begin
          bad = 1'b1;
        end
      end else if (s1_byte_r == BYTE_ESC) begin
        esc_nxt = 1'b1;
      end else begin
        take = 1'b1;
      end
    end

    if (take) begin
      case (phase_r)
        PH_HEADER: begin
          crc_nxt = crc_upd;
          case (hdr_cnt_r)
            3'd0:    addr_nxt  = db;
            3'd1:    cmd_nxt   = db;
            3'd2:    flags_nxt = db;
            3'd3:    seq_nxt   = {seq_r[15:8], db};
            3'd4:    seq_nxt   = {db, seq_r[7:0]};
            3'd5:    len_nxt   = {len_r[15:8], db};
            default: len_nxt   = len_new;
          endcase
          if (hdr_cnt_r >= HDR_LAST) begin
            hdr_cnt_nxt = 3'd0;
            pay_cnt_nxt = 16'd0;
            phase_nxt   = (len_new != 16'd0) ? PH_PAYLOAD : PH_CRC;
          end else begin
            hdr_cnt_nxt = hdr_cnt_r + 3'd1;
          end
        end
        PH_PAYLOAD: begin
          crc_nxt     = crc_upd;
          pay_cnt_nxt = pay_cnt_inc;
          res_valid   = 1'b1;
          res_kind    = KIND_PAYLOAD;
          res_pbyte   = db;
          res_last    = (pay_cnt_inc >= len_r);
          if (pay_cnt_inc >= len_r) begin
            phase_nxt = PH_CRC;
          end
        end
        PH_CRC: begin
          if (!crc_cnt_r) begin
            crc_hi_nxt  = db;
            crc_cnt_nxt = 1'b1;
          end else begin
            res_valid = 1'b1;
            res_hdr   = 1'b1;
            if ({crc_hi_r, db} == crc_r) begin
              res_kind = KIND_GOOD;
            end else begin
              res_kind = KIND_CRC_ERR;
              if (err_cnt_r != CNT_MAX) begin
                err_cnt_nxt = err_cnt_r + 16'd1;
              end
            end
            phase_nxt   = PH_WAIT;
            esc_nxt     = 1'b0;
            hdr_cnt_nxt = 3'd0;
            pay_cnt_nxt = 16'd0;
            crc_nxt     = CRC_INIT;
            crc_hi_nxt  = 8'h00;
            crc_cnt_nxt = 1'b0;
          end
        end
        default: ;
      endcase
    end

    if (bad) begin
      phase_nxt   = (s1_byte_r == BYTE_SOF) ? PH_HEADER : PH_WAIT;
      esc_nxt     = 1'b0;
      hdr_cnt_nxt = 3'd0;
      pay_cnt_nxt = 16'd0;
      crc_nxt     = CRC_INIT;
      crc_hi_nxt  = 8'h00;
      crc_cnt_nxt = 1'b0;
      if (started) begin
        res_valid = 1'b1;
        res_kind  = KIND_ABORT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_WAIT;
      esc_r     <= 1'b0;
      hdr_cnt_r <= 3'd0;
      addr_r    <= 8'h00;
      cmd_r     <= 8'h00;
      flags_r   <= 8'h00;
      seq_r     <= 16'd0;
      len_r     <= 16'd0;
      pay_cnt_r <= 16'd0;
      crc_r     <= CRC_INIT;
      crc_hi_r  <= 8'h00;
      crc_cnt_r <= 1'b0;
      err_cnt_r <= 16'd0;
    end else if (s1_adv) begin
      phase_r   <= phase_nxt;
      esc_r     <= esc_nxt;
      hdr_cnt_r <= hdr_cnt_nxt;
      addr_r    <= addr_nxt;
      cmd_r     <= cmd_nxt;
      flags_r   <= flags_nxt;
      seq_r     <= seq_nxt;
      len_r     <= len_nxt;
      pay_cnt_r <= pay_cnt_nxt;
      crc_r     <= crc_nxt;
      crc_hi_r  <= crc_hi_nxt;
      crc_cnt_r <= crc_cnt_nxt;
      err_cnt_r <= err_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= res_valid;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && res_valid) begin
      out_kind_r  <= res_kind;
      out_pbyte_r <= res_pbyte;
      out_last_r  <= res_last;
      out_addr_r  <= res_hdr ? addr_r  : 8'h00;
      out_cmd_r   <= res_hdr ? cmd_r   : 8'h00;
      out_flags_r <= res_hdr ? flags_r : 8'h00;
      out_seq_r   <= res_hdr ? seq_r   : 16'd0;
      out_len_r   <= res_hdr ? len_r   : 16'd0;
      out_err_r   <= err_cnt_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_kind            = out_kind_r;
  assign out_payload_byte    = out_pbyte_r;
  assign out_last_payload    = out_last_r;
  assign out_address         = out_addr_r;
  assign out_command         = out_cmd_r;
  assign out_flag_bits       = out_flags_r;
  assign out_sequence_res    = out_seq_r;
  assign out_payload_length  = out_len_r;
  assign out_crc_error_count = out_err_r;

  `ASSERT_NEVER(a_esc_outside_frame, esc_r && (phase_r == PH_WAIT), "escape pending outside a frame")
  `ASSERT_CLK(a_err_monotonic, $past(rst_n) |-> (err_cnt_r >= $past(err_cnt_r)), "error count went down")
  `ASSERT_NEVER(a_payload_no_header, out_valid_r && (out_kind_r == KIND_PAYLOAD) && ((out_addr_r != 8'h00) || (out_len_r != 16'd0)), "header fields on a payload item")
  `ASSERT_NEVER(a_verdict_clean, out_valid_r && (out_kind_r != KIND_PAYLOAD) && (out_last_r || (out_pbyte_r != 8'h00)), "payload data on a non-payload item")

endmodule

// ----- bench/stuffed_frame_deframer_crc16_top_tb.sv -----
// Testbench for stuffed_frame_deframer_crc16_top: drives stuffed frames, including broken ones,
// and checks every result against a byte-serial deframer model kept in the bench.
// Depends on sfd_pkg and the top level RTL.
`timescale 1ns / 1ps

module stuffed_frame_deframer_crc16_top_tb;
  import sfd_pkg::*;

  localparam int CYCLE_LIMIT = 300000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  pbyte;
    logic        last;
    logic [7:0]  addr;
    logic [7:0]  cmd;
    logic [7:0]  flg;
    logic [15:0] seq;
    logic [15:0] len;
    logic [15:0] errs;
  } deframe_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_line_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_payload_byte;
  logic        out_last_payload;
  logic [7:0]  out_address;
  logic [7:0]  out_command;
  logic [7:0]  out_flag_bits;
  logic [15:0] out_sequence_res;
  logic [15:0] out_payload_length;
  logic [15:0] out_crc_error_count;

  logic [7:0]      line_q[$];
  deframe_result_t pending_results[$];
  int              send_gap_pct = 0;
  int              recv_stall_pct = 0;
  int              mismatches = 0;
  int              cycles = 0;
  bit              in_took = 1'b0;

  // deframer model state
  phase_t      rx_phase = PH_WAIT;
  logic        esc_seen = 1'b0;
  logic [2:0]  hdr_idx = 3'd0;
  logic [7:0]  hdr_addr = 8'h00, hdr_cmd = 8'h00, hdr_flags = 8'h00;
  logic [15:0] hdr_seq = 16'h0000, hdr_len = 16'h0000, pay_cnt = 16'h0000;
  logic [15:0] crc_run = CRC_INIT;
  logic [7:0]  crc_hi = 8'h00;
  logic        crc_half = 1'b0;
  logic [15:0] crc_err_cnt = 16'h0000;

  stuffed_frame_deframer_crc16_top dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_line_byte        (in_line_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_kind            (out_kind),
    .out_payload_byte    (out_payload_byte),
    .out_last_payload    (out_last_payload),
    .out_address         (out_address),
    .out_command         (out_command),
    .out_flag_bits       (out_flag_bits),
    .out_sequence_res    (out_sequence_res),
    .out_payload_length  (out_payload_length),
    .out_crc_error_count (out_crc_error_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // bit-serial CRC16-CCITT, MSB first
  function automatic logic [15:0] crc_ccitt_step(input logic [15:0] acc, input logic [7:0] d);
    logic fb;
    for (int k = 7; k >= 0; k--) begin
      fb  = acc[15] ^ d[k];
      acc = {acc[14:0], 1'b0};
      if (fb) begin
        acc = acc ^ CRC_POLY;
      end
    end
    return acc;
  endfunction

  function automatic deframe_result_t make_result(input logic [1:0] k, input logic [7:0] pb,
                                                  input logic lst, input bit with_hdr);
    deframe_result_t r;
    r.kind  = k;
    r.pbyte = pb;
    r.last  = lst;
    r.addr  = with_hdr ? hdr_addr : 8'h00;
    r.cmd   = with_hdr ? hdr_cmd : 8'h00;
    r.flg   = with_hdr ? hdr_flags : 8'h00;
    r.seq   = with_hdr ? hdr_seq : 16'h0000;
    r.len   = with_hdr ? hdr_len : 16'h0000;
    r.errs  = crc_err_cnt;
    return r;
  endfunction

  task automatic clear_frame();
    rx_phase = PH_WAIT;
    esc_seen = 1'b0;
    hdr_idx  = 3'd0;
    pay_cnt  = 16'h0000;
    crc_run  = CRC_INIT;
    crc_hi   = 8'h00;
    crc_half = 1'b0;
  endtask

  task automatic deframe_byte(input logic [7:0] raw);
    logic [7:0]  b;
    logic        started;
    logic        lst;
    logic [15:0] rx_crc;
    b = raw;
    started = (rx_phase == PH_PAYLOAD && pay_cnt != 16'h0000) ||
              (rx_phase == PH_CRC && hdr_len != 16'h0000);
    if (b == BYTE_SOF) begin
      clear_frame();
      rx_phase = PH_HEADER;
      if (started) begin
        pending_results.push_back(make_result(KIND_ABORT, 8'h00, 1'b0, 1'b0));
      end
    end else if (rx_phase == PH_WAIT) begin
      // idle line, byte ignored
    end else if (esc_seen && b != BYTE_ESC_SOF && b != BYTE_ESC_ESC) begin
      clear_frame();
      if (started) begin
        pending_results.push_back(make_result(KIND_ABORT, 8'h00, 1'b0, 1'b0));
      end
    end else if (!esc_seen && b == BYTE_ESC) begin
      esc_seen = 1'b1;
    end else begin
      if (esc_seen) begin
        b = (b == BYTE_ESC_SOF) ? BYTE_SOF : BYTE_ESC;
      end
      esc_seen = 1'b0;
      case (rx_phase)
        PH_HEADER: begin
          crc_run = crc_ccitt_step(crc_run, b);
          case (hdr_idx)
            3'd0: hdr_addr = b;
            3'd1: hdr_cmd = b;
            3'd2: hdr_flags = b;
            3'd3: hdr_seq[7:0] = b;
            3'd4: hdr_seq[15:8] = b;
            3'd5: hdr_len[7:0] = b;
            default: hdr_len[15:8] = b;
          endcase
          if (hdr_idx >= HDR_LAST) begin
            hdr_idx  = 3'd0;
            pay_cnt  = 16'h0000;
            rx_phase = (hdr_len != 16'h0000) ? PH_PAYLOAD : PH_CRC;
          end else begin
            hdr_idx = hdr_idx + 3'd1;
          end
        end
        PH_PAYLOAD: begin
          crc_run = crc_ccitt_step(crc_run, b);
          pay_cnt = pay_cnt + 16'd1;
          lst = (pay_cnt >= hdr_len);
          if (lst) begin
            rx_phase = PH_CRC;
          end
          pending_results.push_back(make_result(KIND_PAYLOAD, b, lst, 1'b0));
        end
        default: begin
          if (!crc_half) begin
            crc_hi   = b;
            crc_half = 1'b1;
          end else begin
            rx_crc = {crc_hi, b};
            if (rx_crc != crc_run && crc_err_cnt != CNT_MAX) begin
              crc_err_cnt = crc_err_cnt + 16'd1;
            end
            pending_results.push_back(make_result((rx_crc == crc_run) ? KIND_GOOD : KIND_CRC_ERR,
                                                  8'h00, 1'b0, 1'b1));
            clear_frame();
          end
        end
      endcase
    end
  endtask

  function automatic logic [7:0] rand_line_byte();
    case ($urandom_range(0, 9))
      0: return BYTE_SOF;
      1: return BYTE_ESC;
      2: return BYTE_ESC_SOF;
      3: return BYTE_ESC_ESC;
      default: return 8'($urandom);
    endcase
  endfunction

  // builds one stuffed frame; a cut frame ends early with a restart or a bad escape
  task automatic queue_frame(input logic [7:0] addr, input logic [7:0] cmd, input logic [7:0] flg,
                             input logic [15:0] seq, input logic [15:0] len,
                             input bit bad_crc, input bit cut, input bit bad_esc);
    logic [7:0]  raw_q[$];
    logic [7:0]  wire_q[$];
    logic [15:0] crc;
    logic [7:0]  junk;
    int          n_pay;
    int          keep;
    raw_q = '{addr, cmd, flg, seq[7:0], seq[15:8], len[7:0], len[15:8]};
    n_pay = (cut && len > 16'd48) ? 48 : int'(len);
    for (int i = 0; i < n_pay; i++) begin
      raw_q.push_back(rand_line_byte());
    end
    crc = CRC_INIT;
    foreach (raw_q[i]) begin
      crc = crc_ccitt_step(crc, raw_q[i]);
    end
    if (bad_crc) begin
      crc = crc ^ (16'd1 << $urandom_range(0, 15));
    end
    raw_q.push_back(crc[15:8]);
    raw_q.push_back(crc[7:0]);
    foreach (raw_q[i]) begin
      if (raw_q[i] == BYTE_SOF) begin
        wire_q.push_back(BYTE_ESC);
        wire_q.push_back(BYTE_ESC_SOF);
      end else if (raw_q[i] == BYTE_ESC) begin
        wire_q.push_back(BYTE_ESC);
        wire_q.push_back(BYTE_ESC_ESC);
      end else begin
        wire_q.push_back(raw_q[i]);
      end
    end
    keep = cut ? $urandom_range(1, wire_q.size() - 1) : wire_q.size();
    line_q.push_back(BYTE_SOF);
    for (int i = 0; i < keep; i++) begin
      line_q.push_back(wire_q[i]);
    end
    if (cut) begin
      if (bad_esc) begin
        junk = 8'($urandom);
        while (junk == BYTE_ESC_SOF || junk == BYTE_ESC_ESC) begin
          junk = 8'($urandom);
        end
        line_q.push_back(BYTE_ESC);
        line_q.push_back(junk);
      end else begin
        line_q.push_back(BYTE_SOF);
      end
    end
  endtask

  task automatic drain();
    while (line_q.size() != 0 || in_valid || pending_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input int target);
    int         count;
    int         roll;
    int         n0;
    logic [15:0] len;
    logic [7:0] junk;
    bit         cut;
    send_gap_pct   = send_pct;
    recv_stall_pct = recv_pct;
    count = 0;
    while (count < target) begin
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        repeat ($urandom_range(1, 4)) begin
          junk = 8'($urandom);
          if (junk == BYTE_SOF) begin
            junk = 8'h3C;
          end
          line_q.push_back(junk);
        end
      end else begin
        n0  = line_q.size();
        len = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(13, 40))
                                          : 16'($urandom_range(0, 12));
        cut = (roll >= 18 && roll < 33);
        if (cut && $urandom_range(0, 1) == 1) begin
          len = 16'($urandom);
        end
        queue_frame(rand_line_byte(), rand_line_byte(), rand_line_byte(), 16'($urandom), len,
                    roll < 18, cut, $urandom_range(0, 1) == 1);
        count += line_q.size() - n0;
      end
    end
    drain();
  endtask

  task automatic cmp_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    deframe_result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          $display("%0t: result with none expected, expected nothing, got kind %0d",
                   $time, out_kind);
        end else begin
          want = pending_results.pop_front();
          cmp_field("kind", 16'(want.kind), 16'(out_kind));
          cmp_field("payload_byte", 16'(want.pbyte), 16'(out_payload_byte));
          cmp_field("last_payload", 16'(want.last), 16'(out_last_payload));
          cmp_field("address", 16'(want.addr), 16'(out_address));
          cmp_field("command", 16'(want.cmd), 16'(out_command));
          cmp_field("flag_bits", 16'(want.flg), 16'(out_flag_bits));
          cmp_field("sequence", want.seq, out_sequence_res);
          cmp_field("payload_length", want.len, out_payload_length);
          cmp_field("crc_error_count", want.errs, out_crc_error_count);
        end
      end
      in_took = in_valid && in_ready;
      if (in_took) begin
        deframe_byte(in_line_byte);
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_took)) begin
      if (line_q.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
        in_valid     <= 1'b1;
        in_line_byte <= line_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[stuffed_frame_deframer_crc16_top] ERROR");
      $finish;
    end
  end

  initial begin
    send_gap_pct   = 24;
    recv_stall_pct = 53;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // noise outside a frame, escape included
    line_q.push_back(8'h5A);
    line_q.push_back(BYTE_ESC);
    line_q.push_back(8'hFF);
    // one payload byte, then a restart before the trailer
    line_q = {line_q, BYTE_SOF, 8'h00, 8'h01, 8'h80, 8'hFF, 8'hFF, 8'h01, 8'h00, 8'h7E};
    line_q.push_back(BYTE_SOF);
    // bad escape inside the header
    line_q = {line_q, 8'h11, BYTE_ESC, 8'h00};
    // zero length, header bytes that need stuffing
    queue_frame(BYTE_SOF, BYTE_ESC, 8'hFF, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0);

    run_phase(24, 53, 230);
    run_phase(53, 24, 230);
    run_phase(0, 0, 230);
    repeat (10) @(posedge clk);

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("[stuffed_frame_deframer_crc16_top] OK");
    end else begin
      $display("[stuffed_frame_deframer_crc16_top] ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/sfd_pkg.sv
rtl/core/stuffed_frame_deframer_crc16_top.sv
bench/stuffed_frame_deframer_crc16_top_tb.sv
